@@ design/ibs_pkg.sv @@
`timescale 1ns / 1ps

package ibs_pkg;

  localparam int PIXEL_BITS      = 8;
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int ROW_W        = 13;
  localparam int OUT_ROW_W    = HEIGHT_REG_W - 1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1;

  localparam logic ACT_DRAIN = 1'b1;

  localparam int SUM_W     = PIXEL_BITS + 4;
  localparam int DIV_SHIFT = SUM_W + 4;
  localparam int RECIP_W   = DIV_SHIFT + 1;

  localparam logic [RECIP_W-1:0] RECIP_ONE   = RECIP_W'(1) << DIV_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_THREE = RECIP_W'(((1 << DIV_SHIFT) + 2) / 3);
  localparam logic [RECIP_W-1:0] RECIP_NINE  = RECIP_W'(((1 << DIV_SHIFT) + 8) / 9);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  action;
    logic [PIXEL_BITS-1:0] pixel;
  } item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] smoothed;
    logic                  frame_end;
  } result_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic has_top;
    logic has_bot;
    logic has_left;
    logic has_right;
  } ibs_ctl_t;

endpackage

@@ design/ibs_front.sv @@
`timescale 1ns / 1ps

module ibs_front import ibs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [COL_W-1:0]      push_col,
  output ibs_ctl_t              push_ctl,
  output logic [PIXEL_BITS-1:0] push_pix
);

  localparam int EW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (EW_W > WIDTH_REG_W) ? EW_W : WIDTH_REG_W;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [COL_W-1:0]        in_column;
  logic [ROW_W-1:0]        in_row;
  logic [COL_W-1:0]        out_column;
  logic [OUT_ROW_W-1:0]    out_row;

  logic [CMP_W-1:0]        wreg_x;
  logic [EW_W-1:0]         eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;
  logic [EW_W-1:0]         icol_inc;
  logic [EW_W-1:0]         ocol_inc;
  logic [ROW_W-1:0]        orow_inc;
  logic                    col_wrap;
  logic                    emit;
  logic                    has_bot;
  logic                    has_right;
  logic                    last;
  logic                    accept;

  assign cfg_ready  = 1'b1;
  assign item_ready = push_ready;
  assign push_valid = item_valid;
  assign accept     = item_valid && push_ready;

  assign wreg_x = CMP_W'(width_reg);
  assign eff_w  = (width_reg == '0) ? EW_W'(1) :
                  (wreg_x > CMP_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : EW_W'(wreg_x);
  assign eff_h  = (height_reg == '0) ? HEIGHT_REG_W'(1) : height_reg;

  assign icol_inc = EW_W'(in_column) + EW_W'(1);
  assign ocol_inc = EW_W'(out_column) + EW_W'(1);
  assign orow_inc = ROW_W'(out_row) + ROW_W'(1);

  assign col_wrap  = icol_inc >= eff_w;
  assign emit      = (in_row > ROW_W'(1)) || ((in_row == ROW_W'(1)) && (in_column != '0));
  assign has_bot   = orow_inc < eff_h;
  assign has_right = ocol_inc < eff_w;
  assign last      = !has_bot && !has_right;

  always_comb begin
    push_col           = in_column;
    push_pix           = (item.action == ACT_DRAIN) ? '0 : item.pixel;
    push_ctl.emit      = emit;
    push_ctl.last      = emit && last;
    push_ctl.has_top   = out_row != '0;
    push_ctl.has_bot   = has_bot;
    push_ctl.has_left  = out_column != '0;
    push_ctl.has_right = has_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
        endcase
      end
      if (accept) begin
        if (emit && last) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
        end else begin
          if (col_wrap) begin
            in_column <= '0;
            in_row    <= in_row + ROW_W'(1);
          end else begin
            in_column <= icol_inc[COL_W-1:0];
          end
          if (emit) begin
            if (!has_right) begin
              out_column <= '0;
              out_row    <= orow_inc[OUT_ROW_W-1:0];
            end else begin
              out_column <= ocol_inc[COL_W-1:0];
            end
          end
        end
      end
    end
  end

endmodule

@@ design/ibs_queue.sv @@
`timescale 1ns / 1ps

module ibs_queue import ibs_pkg::*; #(
  parameter int DEPTH  = DEF_QUEUE_DEPTH,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/ibs_back.sv @@
`timescale 1ns / 1ps

module ibs_back import ibs_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int COL_W = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [COL_W-1:0]      q_col,
  input  ibs_ctl_t              q_ctl,
  input  logic [PIXEL_BITS-1:0] q_pix,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  localparam int LB_W   = 2 * PIXEL_BITS;
  localparam int PROD_W = SUM_W + RECIP_W;

  logic [LB_W-1:0]       lbuf [MAX_WIDTH];
  logic [LB_W-1:0]       rd_q;
  logic [LB_W-1:0]       byp_data;
  logic                  byp;
  logic [LB_W-1:0]       rd_eff;
  logic [LB_W-1:0]       wdata;
  logic                  adv;

  logic                  s1_valid;
  ibs_ctl_t              s1_ctl;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [COL_W-1:0]      s1_col;

  logic                  s2_valid;
  ibs_ctl_t              s2_ctl;
  logic [PIXEL_BITS-1:0] win [3][3];
  logic [PIXEL_BITS-1:0] base [3][3];
  logic                  clr_win;
  logic [2:0]            row_en;
  logic [2:0]            col_en;
  logic [SUM_W-1:0]      row_sum [3];
  logic [SUM_W-1:0]      sum;
  logic [1:0]            shift;
  logic [1:0]            threes;

  logic                  s3_valid;
  logic                  s3_last;
  logic [SUM_W-1:0]      s3_sum;
  logic [1:0]            s3_shift;
  logic [1:0]            s3_threes;
  logic [SUM_W-1:0]      scaled;
  logic [RECIP_W-1:0]    recip;
  logic [PROD_W-1:0]     prod;

  assign adv     = !result_valid || result_ready;
  assign q_ready = adv;

  // line buffer entry holds {row above, current row} for one column
  assign rd_eff = byp ? byp_data : rd_q;
  assign wdata  = {rd_eff[PIXEL_BITS-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid) begin
        lbuf[s1_col] <= wdata;
      end
      rd_q     <= lbuf[q_col];
      byp      <= s1_valid && (q_col == s1_col);
      byp_data <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= q_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid && s2_ctl.emit;
      result_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl           <= q_ctl;
      s1_pix           <= q_pix;
      s1_col           <= q_col;
      s2_ctl           <= s1_ctl;
      s3_sum           <= sum;
      s3_shift         <= shift;
      s3_threes        <= threes;
      s3_last          <= s2_ctl.last;
      result.smoothed  <= prod[DIV_SHIFT +: PIXEL_BITS];
      result.frame_end <= s3_last;
    end
  end

  // start from an empty window after the last output of a frame
  assign clr_win = s2_valid && s2_ctl.last;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        base[r][c] = clr_win ? '0 : win[r][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (adv) begin
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= base[r][1];
          win[r][1] <= base[r][2];
        end
        win[0][2] <= rd_eff[LB_W-1:PIXEL_BITS];
        win[1][2] <= rd_eff[PIXEL_BITS-1:0];
        win[2][2] <= s1_pix;
      end else if (clr_win) begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            win[r][c] <= '0;
          end
        end
      end
    end
  end

  assign row_en = {s2_ctl.has_bot, 1'b1, s2_ctl.has_top};
  assign col_en = {s2_ctl.has_right, 1'b1, s2_ctl.has_left};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = '0;
      for (int c = 0; c < 3; c++) begin
        row_sum[r] = row_sum[r] +
                     ((row_en[r] && col_en[c]) ? SUM_W'(win[r][c]) : SUM_W'(0));
      end
    end
    sum = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // divisor = 2^shift * 3^threes
  assign shift  = {1'b0, s2_ctl.has_top ^ s2_ctl.has_bot} +
                  {1'b0, s2_ctl.has_left ^ s2_ctl.has_right};
  assign threes = {1'b0, s2_ctl.has_top & s2_ctl.has_bot} +
                  {1'b0, s2_ctl.has_left & s2_ctl.has_right};

  assign scaled = s3_sum >> s3_shift;

  always_comb begin
    case (s3_threes)
      2'd0:    recip = RECIP_ONE;
      2'd1:    recip = RECIP_THREE;
      default: recip = RECIP_NINE;
    endcase
  end

  assign prod = PROD_W'(scaled) * PROD_W'(recip);

endmodule

@@ design/image_box_smoother_3x3_core.sv @@
`timescale 1ns / 1ps

// 3x3 box smoother with border-aware averaging. Pixels enter in raster order,
// one per clock sustained while results are taken, and each result is the
// floor of the mean of the in-image neighbors (1, 2, 3, 4, 6 or 9 of them). A
// result trails its pixel by image_width+1 items, so send image_width+1 drain
// items after a frame to flush it; the last result of the frame carries
// frame_end. The front end tracks positions and tags each item, a short queue
// decouples it from the back end, and the back end pops the queue and reads the
// line buffer, shifts the window, sums the neighbors, then scales the sum by a
// reciprocal into the output register. The whole back end holds while a result
// waits, and the input stalls only once the queue is full. Throughput is one
// item per clock while results are taken, bounded by the single line-buffer
// memory, which is read and written once per item with a bypass for
// back-to-back use of one column. cfg_ready stays high; the user must write
// configuration only while the block is idle, which the block leaves unchecked.

module image_box_smoother_3x3_core import ibs_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CTL_W   = $bits(ibs_ctl_t);
  localparam int ENTRY_W = COL_W + CTL_W + PIXEL_BITS;

  logic                  fr_valid;
  logic                  fr_ready;
  logic [COL_W-1:0]      fr_col;
  ibs_ctl_t              fr_ctl;
  logic [PIXEL_BITS-1:0] fr_pix;
  logic [ENTRY_W-1:0]    fr_data;

  logic                  q_valid;
  logic                  q_ready;
  logic [ENTRY_W-1:0]    q_data;

  ibs_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_col   (fr_col),
    .push_ctl   (fr_ctl),
    .push_pix   (fr_pix)
  );

  assign fr_data = {fr_col, fr_ctl, fr_pix};

  ibs_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  ibs_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_col        (q_data[ENTRY_W-1 -: COL_W]),
    .q_ctl        (ibs_ctl_t'(q_data[PIXEL_BITS +: CTL_W])),
    .q_pix        (q_data[PIXEL_BITS-1:0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ design/ibs_checker.sv @@
`timescale 1ns / 1ps

module ibs_checker import ibs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("outputs not cleared by reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    $fell(item_ready) |-> $past(result_valid && !result_ready))
    else $error("input stalled without output stall");

endmodule

bind image_box_smoother_3x3_core ibs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ibs_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int CALM_ITEMS    = 250;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;

  image_box_smoother_3x3_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // smoother state mirrored from the block
  int                    reg_width;
  int                    reg_height;
  logic [PIXEL_BITS-1:0] line_above [MAX_W];
  logic [PIXEL_BITS-1:0] line_cur [MAX_W];
  logic [PIXEL_BITS-1:0] win [9];
  int                    in_col;
  int                    in_row;
  int                    out_col;
  int                    out_row;

  result_t smoothed_q [$];
  result_t head;
  int      errors = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      n_frames = 0;
  int      stall_cycles = 0;
  int      ready_hold = 0;
  bit      calm = 1'b0;

  function automatic int eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > MAX_W) return MAX_W;
    return reg_width;
  endfunction

  function automatic int eff_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < 9; i++) win[i] = '0;
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic reset_model();
    reg_width = int'(WIDTH_RESET);
    reg_height = int'(HEIGHT_RESET);
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i] = '0;
      line_cur[i] = '0;
    end
    clear_frame();
  endtask

  task automatic predict_smooth(input item_t it);
    int                    w;
    int                    h;
    int                    sum;
    int                    cnt;
    int                    rr;
    int                    cc;
    logic [PIXEL_BITS-1:0] x_in;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    bit                    emit;
    bit                    has_top;
    bit                    has_bot;
    bit                    has_left;
    bit                    has_right;
    bit                    is_last;
    result_t               r;
    w = eff_width();
    h = eff_height();
    x_in = (it.action == ACT_DRAIN) ? '0 : it.pixel;
    up = line_above[in_col];
    mid = line_cur[in_col];
    line_above[in_col] = mid;
    line_cur[in_col] = x_in;
    for (rr = 0; rr < 3; rr++) begin
      win[rr * 3] = win[rr * 3 + 1];
      win[rr * 3 + 1] = win[rr * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = x_in;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row++;
    end else begin
      in_col++;
    end
    if (emit) begin
      has_top = out_row > 0;
      has_bot = out_row + 1 < h;
      has_left = out_col > 0;
      has_right = out_col + 1 < w;
      sum = 0;
      cnt = 0;
      for (rr = 0; rr < 3; rr++) begin
        for (cc = 0; cc < 3; cc++) begin
          if (!((rr == 0 && !has_top) || (rr == 2 && !has_bot) ||
                (cc == 0 && !has_left) || (cc == 2 && !has_right))) begin
            sum += win[rr * 3 + cc];
            cnt++;
          end
        end
      end
      is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
      r.smoothed = PIXEL_BITS'(sum / cnt);
      r.frame_end = is_last;
      smoothed_q.push_back(r);
      if (is_last) begin
        clear_frame();
        n_frames++;
      end else if (out_col + 1 >= w) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  function automatic item_t pixel_item(input logic [PIXEL_BITS-1:0] v);
    item_t it;
    it.action = ~ACT_DRAIN;
    it.pixel = v;
    return it;
  endfunction

  function automatic item_t drain_item();
    item_t it;
    it.action = ACT_DRAIN;
    it.pixel = PIXEL_BITS'($urandom);
    return it;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] random_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return PIXEL_BITS'($urandom);
  endfunction

  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_smooth(it);
    n_items++;
  endtask

  task automatic wait_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (smoothed_q.size() != 0) @(posedge clk);
  endtask

  task automatic configure(input int w, input int h);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_width = w & 'h7FF;
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_height = h & 'h1FFF;
    cfg_valid <= 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int v);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) reg_width = v & 'h7FF;
    else reg_height = v & 'h1FFF;
    cfg_valid <= 1'b0;
  endtask

  // style 0: drains, 1: pixels, 2: mixed
  task automatic flush_frame(input int style);
    while (in_col != 0 || in_row != 0) begin
      if (style == 1 || (style == 2 && $urandom_range(0, 1) == 1))
        send_item(pixel_item(random_pixel()));
      else
        send_item(drain_item());
    end
  endtask

  task automatic send_frame();
    int total;
    int pause_at;
    total = eff_width() * eff_height();
    pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, total - 1) : -1;
    for (int i = 0; i < total; i++) begin
      if (i == pause_at) wait_results();
      if ($urandom_range(0, 11) == 0)
        send_item(drain_item());
      else
        send_item(pixel_item(random_pixel()));
    end
  endtask

  task automatic random_setting();
    int w;
    int h;
    w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    if ($urandom_range(0, 19) == 0) w = 0;
    if ($urandom_range(0, 19) == 0) h = 0;
    configure(w, h);
    repeat ($urandom_range(1, 3)) begin
      send_frame();
      flush_frame($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) wait_results();
    end
  endtask

  task automatic test_reset_size();
    write_reg(REG_IMAGE_WIDTH, 6);
    send_frame();
    flush_frame(0);
  endtask

  task automatic test_borders();
    int vals [9] = '{255, 0, 200, 17, 255, 1, 128, 254, 255};
    configure(3, 3);
    for (int i = 0; i < 9; i++) send_item(pixel_item(PIXEL_BITS'(vals[i])));
    flush_frame(0);
    configure(3, 1);
    send_item(pixel_item('1));
    send_item(drain_item());
    send_item(pixel_item('1));
    flush_frame(1);
    configure(1, 1);
    send_item(pixel_item('1));
    flush_frame(2);
  endtask

  task automatic test_tall_column();
    configure(1, 150);
    send_frame();
    flush_frame(0);
  endtask

  task automatic test_size_limits();
    configure(0, 0);
    send_frame();
    flush_frame(1);
    configure(0, 5);
    send_frame();
    flush_frame(2);
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = n_items + RANDOM_ITEMS;
    while (n_items < stop_at) random_setting();
  endtask

  task automatic test_calm();
    int stop_at;
    calm = 1'b1;
    stop_at = n_items + CALM_ITEMS;
    while (n_items < stop_at) random_setting();
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      result_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 6);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (smoothed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got smoothed=%0d frame_end=%0b",
                 $time, result.smoothed, result.frame_end);
      end else begin
        head = smoothed_q.pop_front();
        n_results++;
        if (result.smoothed !== head.smoothed) begin
          errors++;
          $display("%0t: smoothed mismatch, expected %0d, got %0d",
                   $time, head.smoothed, result.smoothed);
        end
        if (result.frame_end !== head.frame_end) begin
          errors++;
          $display("%0t: frame_end mismatch, expected %0b, got %0b",
                   $time, head.frame_end, result.frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, smoothed_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    item_valid <= 1'b0;
    item <= '0;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_size();
    test_borders();
    test_tall_column();
    test_size_limits();
    test_random();
    test_calm();

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d pixels and drains sent, %0d smoothed pixels checked, %0d frames",
             n_items, n_results, n_frames);
    $display("summary: reset height, zero sizes, 1x1 to 64-wide and 150-tall frames, borders");
    if (errors == 0 && smoothed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
